@@ design/bb3_pkg.sv @@
`default_nettype none

package bb3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int PIX_W       = 8;
  localparam int COORD_W     = $clog2(MAX_WIDTH);
  localparam int DIM_W       = 11;
  localparam int SUM_W       = 12;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // floor(s / 9) as (s * 3641) >> 15, exact for any sum of nine pixels
  localparam logic [SUM_W-1:0] DIV9_MUL   = 12'd3641;
  localparam int               DIV9_SHIFT = 15;

  // register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // result slots one pixel can release, in delivery order
  localparam int OUT_UL = 0;  // (x-1, y-1)
  localparam int OUT_UR = 1;  // (x,   y-1), right edge
  localparam int OUT_LL = 2;  // (x-1, y),   last row
  localparam int OUT_LR = 3;  // (x,   y),   last pixel of frame
  localparam int NUM_OUTS = 4;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t w_last;
    coord_t h_last;
  } geom_t;

  typedef struct packed {
    pix_t [2:0][2:0]     win;    // [column x-2..x][lane cur, prior, older]
    coord_t              x;
    coord_t              y;
    logic                x_one;
    logic                x_zero;
    logic                y_one;
    logic                y_zero;
    logic [NUM_OUTS-1:0] outs;
  } job_t;

  function automatic coord_t dim_last(input logic [DIM_W-1:0] v, input int maxv);
    coord_t r;
    if (v == '0) begin
      r = '0;
    end else if (v > DIM_W'(maxv)) begin
      r = COORD_W'(maxv - 1);
    end else begin
      r = COORD_W'(v - 1'b1);
    end
    return r;
  endfunction

  function automatic pix_t div9(input logic [SUM_W-1:0] s);
    logic [2*SUM_W-1:0] p;
    p = {{SUM_W{1'b0}}, s} * {{SUM_W{1'b0}}, DIV9_MUL};
    return p[DIV9_SHIFT +: PIX_W];
  endfunction

endpackage

`default_nettype wire

@@ design/bb3_pix_if.sv @@
`default_nettype none

interface bb3_pix_if;
  logic                valid;
  logic                ready;
  logic [bb3_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

`default_nettype wire

@@ design/bb3_res_if.sv @@
`default_nettype none

interface bb3_res_if;
  logic                        valid;
  logic                        ready;
  logic [bb3_pkg::PIX_W-1:0]   pixel_out;
  logic [bb3_pkg::COORD_W-1:0] out_col;
  logic [bb3_pkg::COORD_W-1:0] out_row;
  logic                        run_last;
  logic                        frame_done;

  modport source (output valid, output pixel_out, output out_col, output out_row,
                  output run_last, output frame_done, input ready);
  modport sink   (input valid, input pixel_out, input out_col, input out_row,
                  input run_last, input frame_done, output ready);
endinterface

`default_nettype wire

@@ design/bb3_front.sv @@
`default_nettype none

module bb3_front (
  input  logic                         clk,
  input  logic                         rst,
  input  bb3_pkg::geom_t               geom,
  input  logic                         restart,
  bb3_pix_if.sink                      pixels,
  input  logic [bb3_pkg::QCNT_W-1:0]   q_level,
  output logic                         push,
  output bb3_pkg::job_t                job
);

  // line store entry: {older row, prior row}
  logic [2*bb3_pkg::PIX_W-1:0] store [bb3_pkg::MAX_WIDTH];
  logic [2*bb3_pkg::PIX_W-1:0] rd_data;
  logic [2*bb3_pkg::PIX_W-1:0] wr_data;

  bb3_pkg::coord_t             col_count;
  bb3_pkg::coord_t             row_count;
  logic                        s1_valid;
  bb3_pkg::pix_t               s1_pix;
  bb3_pkg::coord_t             s1_x;
  bb3_pkg::coord_t             s1_y;
  bb3_pkg::pix_t [1:0][2:0]    win;
  logic [bb3_pkg::QCNT_W-1:0]  pending;
  logic                        accept;
  logic                        last_col;
  logic                        last_row;

  // hold off input unless the queue has room for everything in flight
  assign pending      = q_level + {{(bb3_pkg::QCNT_W-1){1'b0}}, s1_valid};
  assign pixels.ready = pending < bb3_pkg::QCNT_W'(bb3_pkg::QUEUE_DEPTH);
  assign accept       = pixels.valid && pixels.ready;

  assign wr_data = {rd_data[bb3_pkg::PIX_W-1:0], s1_pix};

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      store[s1_x] <= wr_data;
    end
    if (accept) begin
      // forward the write in progress when the row is one pixel wide
      rd_data <= (s1_valid && s1_x == col_count) ? wr_data : store[col_count];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_count <= '0;
      row_count <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (col_count == geom.w_last) begin
          col_count <= '0;
          row_count <= (row_count == geom.h_last) ? '0 : row_count + 1'b1;
        end else begin
          col_count <= col_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= pixels.pixel_in;
      s1_x   <= col_count;
      s1_y   <= row_count;
    end
    if (s1_valid) begin
      win <= job.win[2:1];
    end
  end

  assign last_col = s1_x == geom.w_last;
  assign last_row = s1_y == geom.h_last;

  always_comb begin
    job.win[2] = {rd_data[2*bb3_pkg::PIX_W-1:bb3_pkg::PIX_W],
                  rd_data[bb3_pkg::PIX_W-1:0], s1_pix};
    job.win[1] = win[1];
    job.win[0] = win[0];
    job.x      = s1_x;
    job.y      = s1_y;
    job.x_one  = s1_x == bb3_pkg::COORD_W'(1);
    job.x_zero = s1_x == '0;
    job.y_one  = s1_y == bb3_pkg::COORD_W'(1);
    job.y_zero = s1_y == '0;
    job.outs[bb3_pkg::OUT_UL] = !job.y_zero && !job.x_zero;
    job.outs[bb3_pkg::OUT_UR] = !job.y_zero && last_col;
    job.outs[bb3_pkg::OUT_LL] = last_row && !job.x_zero;
    job.outs[bb3_pkg::OUT_LR] = last_row && last_col;
  end

  assign push = s1_valid && (job.outs != '0);

endmodule

`default_nettype wire

@@ design/bb3_queue.sv @@
`default_nettype none

module bb3_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  bb3_pkg::job_t               job_in,
  input  logic                        pop,
  output bb3_pkg::job_t               head,
  output logic                        head_valid,
  output logic [bb3_pkg::QCNT_W-1:0]  level
);

  bb3_pkg::job_t              entries [bb3_pkg::QUEUE_DEPTH];
  logic [bb3_pkg::QPTR_W-1:0] wr_ptr;
  logic [bb3_pkg::QPTR_W-1:0] rd_ptr;

  assign head       = entries[rd_ptr];
  assign head_valid = level != '0;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/bb3_back.sv @@
`default_nettype none

module bb3_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  bb3_pkg::job_t head,
  output logic          pop,
  bb3_res_if.source     results
);

  bb3_pkg::job_t                 cur;
  logic [bb3_pkg::NUM_OUTS-1:0]  rem;
  logic                          cur_valid;
  logic [bb3_pkg::NUM_OUTS-1:0]  sel;
  logic [bb3_pkg::NUM_OUTS-1:0]  rem_after;
  logic                          cx_left;
  logic                          cy_up;
  logic                          last;
  logic [1:0]                    cidx [3];
  logic [1:0]                    lidx [3];
  logic [bb3_pkg::SUM_W-1:0]     col_sum [3];
  logic [bb3_pkg::SUM_W-1:0]     total;
  logic                          issue;

  logic                          sum_valid;
  logic [bb3_pkg::SUM_W-1:0]     sum_val;
  bb3_pkg::coord_t               s_col;
  bb3_pkg::coord_t               s_row;
  logic                          s_last;
  logic                          s_done;
  logic                          sum_adv;
  logic                          out_adv;
  logic                          out_valid;

  // lowest pending slot goes next
  assign sel       = rem & (~rem + 1'b1);
  assign rem_after = rem & ~sel;
  assign last      = rem_after == '0;
  assign cx_left   = sel[bb3_pkg::OUT_UL] || sel[bb3_pkg::OUT_LL];
  assign cy_up     = sel[bb3_pkg::OUT_UL] || sel[bb3_pkg::OUT_UR];

  // clamp window columns and rows to the frame edges
  always_comb begin
    if (cx_left) begin
      cidx[0] = cur.x_one ? 2'd1 : 2'd0;
      cidx[1] = 2'd1;
      cidx[2] = 2'd2;
    end else begin
      cidx[0] = cur.x_zero ? 2'd2 : 2'd1;
      cidx[1] = 2'd2;
      cidx[2] = 2'd2;
    end
    if (cy_up) begin
      lidx[0] = cur.y_one ? 2'd1 : 2'd2;
      lidx[1] = 2'd1;
      lidx[2] = 2'd0;
    end else begin
      lidx[0] = cur.y_zero ? 2'd0 : 2'd1;
      lidx[1] = 2'd0;
      lidx[2] = 2'd0;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      col_sum[i] = bb3_pkg::SUM_W'(cur.win[cidx[i]][lidx[0]])
                 + bb3_pkg::SUM_W'(cur.win[cidx[i]][lidx[1]])
                 + bb3_pkg::SUM_W'(cur.win[cidx[i]][lidx[2]]);
    end
    total = col_sum[0] + col_sum[1] + col_sum[2];
  end

  assign out_adv = !out_valid || results.ready;
  assign sum_adv = !sum_valid || out_adv;
  assign issue   = cur_valid && sum_adv;
  assign pop     = q_valid && (!cur_valid || (issue && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      sum_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (issue && last) begin
        cur_valid <= 1'b0;
      end
      if (sum_adv) begin
        sum_valid <= issue;
      end
      if (out_adv) begin
        out_valid <= sum_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      rem <= head.outs;
    end else if (issue) begin
      rem <= rem_after;
    end
    if (issue) begin
      sum_val <= total;
      s_col   <= cx_left ? cur.x - 1'b1 : cur.x;
      s_row   <= cy_up ? cur.y - 1'b1 : cur.y;
      s_last  <= last;
      s_done  <= sel[bb3_pkg::OUT_LR];
    end
    if (out_adv && sum_valid) begin
      results.pixel_out  <= bb3_pkg::div9(sum_val);
      results.out_col    <= s_col;
      results.out_row    <= s_row;
      results.run_last   <= s_last;
      results.frame_done <= s_done;
    end
  end

  assign results.valid = out_valid;

endmodule

`default_nettype wire

@@ design/box_blur_3x3_clamped.sv @@
`default_nettype none

// 3x3 box filter, border replicated
//
//  channel   dir  handshake            carries
//  --------  ---  -------------------  ------------------------------------------
//  pixels    in   valid/ready          pixel_in, raster order
//  results   out  valid/ready          pixel_out, out_col, out_row, run_last,
//                                      frame_done
//  APB       in   psel/penable/pready  frame_width @0x0, frame_height @0x4
//
// Takes one pixel per cycle while the job queue has room; the result path
// delivers one result per cycle while results.ready is high, so on the last
// row, where most pixels release two results, input is held back. A result
// passes the front stage, job queue, current-job, sum and output registers.
// Synchronous reset clears the counters, queue and pipeline flags; the line
// stores are not cleared, and border clamping keeps unwritten entries out of
// every result.
// A stall at the result port backs up into a four-entry job queue; input
// ready drops once queued plus in-flight jobs would fill it.

module box_blur_3x3_clamped (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bb3_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bb3_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bb3_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  bb3_pix_if.sink                          pixels,
  bb3_res_if.source                        results
);

  logic [bb3_pkg::DIM_W-1:0]  frame_width;
  logic [bb3_pkg::DIM_W-1:0]  frame_height;
  logic                       cfg_write;
  logic                       reg_idx;
  bb3_pkg::geom_t             geom;

  logic                       push;
  bb3_pkg::job_t              job;
  bb3_pkg::job_t              head;
  logic                       head_valid;
  logic                       pop;
  logic [bb3_pkg::QCNT_W-1:0] q_level;

  // registers sit on word boundaries; the word index picks the register
  assign reg_idx   = paddr[2];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bb3_pkg::DIM_W'(bb3_pkg::MAX_WIDTH);
      frame_height <= bb3_pkg::DIM_W'(bb3_pkg::MAX_HEIGHT);
    end else if (cfg_write) begin
      case (reg_idx)
        bb3_pkg::REG_WIDTH:  frame_width  <= pwdata[bb3_pkg::DIM_W-1:0];
        bb3_pkg::REG_HEIGHT: frame_height <= pwdata[bb3_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bb3_pkg::REG_WIDTH:
        prdata = {{(bb3_pkg::APB_DATA_W-bb3_pkg::DIM_W){1'b0}}, frame_width};
      bb3_pkg::REG_HEIGHT:
        prdata = {{(bb3_pkg::APB_DATA_W-bb3_pkg::DIM_W){1'b0}}, frame_height};
      default:
        prdata = '0;
    endcase
  end

  // zero acts as one, oversize saturates to MAX_WIDTH or MAX_HEIGHT
  assign geom.w_last = bb3_pkg::dim_last(frame_width, bb3_pkg::MAX_WIDTH);
  assign geom.h_last = bb3_pkg::dim_last(frame_height, bb3_pkg::MAX_HEIGHT);

  // front: count position, read and rewrite line stores, shift window,
  // queue a job for every pixel that releases results
  bb3_front u_front (
    .clk     (clk),
    .rst     (rst),
    .geom    (geom),
    .restart (cfg_write),
    .pixels  (pixels),
    .q_level (q_level),
    .push    (push),
    .job     (job)
  );

  bb3_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .job_in     (job),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .level      (q_level)
  );

  // back: walk each job's result slots, sum the clamped window, divide by 9
  bb3_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (head_valid),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule

`default_nettype wire

@@ test/box_blur_3x3_clamped_tb.sv @@
`default_nettype none

module box_blur_3x3_clamped_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 16;  // settle time after the last expected result
  localparam int SPAN_ITEMS = 40;     // pixels sent into an oversized row or column
  localparam int RANDOM_ITEMS = 310;  // pixels sent as random frames

  // One smoothed pixel as it should leave the result port
  typedef struct packed {
    bb3_pkg::pix_t   pix;
    bb3_pkg::coord_t col;
    bb3_pkg::coord_t row;
    logic            last;
    logic            done;
  } blur_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [bb3_pkg::APB_ADDR_W-1:0] paddr;
  logic [bb3_pkg::APB_DATA_W-1:0] pwdata;
  logic [bb3_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  bb3_pix_if pix_ch ();
  bb3_res_if res_ch ();

  box_blur_3x3_clamped dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pixels  (pix_ch),
    .results (res_ch)
  );

  // Predictor state: register copies, raster position and the last three rows
  // of the frame, indexed by row modulo 3. Every window read lands on rows
  // of the current frame that are already complete up to the needed column.
  logic [bb3_pkg::DIM_W-1:0] width_reg;
  logic [bb3_pkg::DIM_W-1:0] height_reg;
  int                        col_pos;
  int                        row_pos;
  bb3_pkg::pix_t             recent_rows [3][bb3_pkg::MAX_WIDTH];
  blur_result_t              expected_blur [$];

  int  errors;
  int  cycles;
  bit  gaps_on;   // sender draws random gaps between pixels
  bit  stall_on;  // receiver draws random stalls between results

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Zero becomes 1, anything past the maximum saturates to it
  function automatic int eff_dim(input logic [bb3_pkg::DIM_W-1:0] v, input int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic int clamp_to(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Truncated mean of the 3x3 window around (cx,cy), edges replicated
  function automatic bb3_pkg::pix_t blur_at(input int cx, input int cy, input int w,
                                            input int h);
    int sum;
    sum = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        sum += recent_rows[clamp_to(cy + dr, h - 1) % 3][clamp_to(cx + dc, w - 1)];
      end
    end
    return bb3_pkg::pix_t'(sum / 9);
  endfunction

  // Store one accepted pixel and queue the results it releases, row-major:
  // upper-left, upper right edge, lower left on the last row, last pixel.
  task automatic predict_pixel(input bb3_pkg::pix_t v);
    int w, h, x, y, n;
    int cx [4];
    int cy [4];
    blur_result_t r;
    w = eff_dim(width_reg, bb3_pkg::MAX_WIDTH);
    h = eff_dim(height_reg, bb3_pkg::MAX_HEIGHT);
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    x = col_pos;
    y = row_pos;
    n = 0;
    recent_rows[y % 3][x] = v;
    if (y >= 1) begin
      if (x >= 1) begin
        cx[n] = x - 1; cy[n] = y - 1; n++;
      end
      if (x == w - 1) begin
        cx[n] = x; cy[n] = y - 1; n++;
      end
    end
    if (y == h - 1) begin
      if (x >= 1) begin
        cx[n] = x - 1; cy[n] = y; n++;
      end
      if (x == w - 1) begin
        cx[n] = x; cy[n] = y; n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      r.pix  = blur_at(cx[k], cy[k], w, h);
      r.col  = bb3_pkg::coord_t'(cx[k]);
      r.row  = bb3_pkg::coord_t'(cy[k]);
      r.last = (k == n - 1);
      r.done = (cx[k] == w - 1) && (cy[k] == h - 1);
      expected_blur.insert(expected_blur.size(), r);
    end
    // advance raster position, wrapping at the end of the frame
    col_pos = x + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = (y + 1 >= h) ? 0 : y + 1;
    end
  endtask

  // Predict and check in one process so that scheduling order never matters:
  // the input transaction is handled before the result one.
  always @(posedge clk) begin : scoreboard
    blur_result_t got;
    blur_result_t want;
    if (!rst) begin
      if (pix_ch.valid && pix_ch.ready) predict_pixel(pix_ch.pixel_in);
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.pixel_out, res_ch.out_col, res_ch.out_row,
                res_ch.run_last, res_ch.frame_done};
        if (expected_blur.size() == 0) begin
          errors++;
          $display("%0t: unexpected result pix=%0d col=%0d row=%0d last=%0b done=%0b",
                   $time, got.pix, got.col, got.row, got.last, got.done);
        end else begin
          want = expected_blur.pop_front();
          if (got.pix !== want.pix || got.col !== want.col || got.row !== want.row ||
              got.last !== want.last || got.done !== want.done) begin
            errors++;
            $display("%0t: mismatch expected pix=%0d col=%0d row=%0d last=%0b done=%0b",
                     $time, want.pix, want.col, want.row, want.last, want.done);
            $display("%0t:          actual   pix=%0d col=%0d row=%0d last=%0b done=%0b",
                     $time, got.pix, got.col, got.row, got.last, got.done);
          end
        end
      end
    end
  end

  // Result side: draw a stall before every transaction, then hold ready
  // until the block delivers.
  initial begin : result_sink
    int stall;
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = stall_on ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        res_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready = 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      @(negedge clk);
    end
  end

  // Send one pixel: optional gap, then hold valid until the transaction.
  // Returns at the falling edge after acceptance, so valid stays high when
  // the next pixel follows with no gap.
  task automatic send_pixel(input bb3_pkg::pix_t v);
    int gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      pix_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_ch.pixel_in = v;
    pix_ch.valid    = 1'b1;
    do @(posedge clk); while (!pix_ch.ready);
    @(negedge clk);
  endtask

  // Mostly uniform, with the extremes drawn more often
  function automatic bb3_pkg::pix_t rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return bb3_pkg::pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Drop valid and wait until every predicted result is out, then let the
  // pipeline run dry: pixels that release no results may still be in flight.
  task automatic wait_drained();
    pix_ch.valid = 1'b0;
    while (expected_blur.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // A register write also restarts the frame
  task automatic write_reg(input logic idx, input logic [bb3_pkg::APB_DATA_W-1:0] data);
    wait_drained();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == bb3_pkg::REG_WIDTH) width_reg = data[bb3_pkg::DIM_W-1:0];
    else height_reg = data[bb3_pkg::DIM_W-1:0];
    col_pos = 0;
    row_pos = 0;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic read_reg(input logic idx);
    logic [bb3_pkg::APB_DATA_W-1:0] want;
    want = (idx == bb3_pkg::REG_WIDTH) ? bb3_pkg::APB_DATA_W'(width_reg)
                                       : bb3_pkg::APB_DATA_W'(height_reg);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      errors++;
      $display("%0t: register %0d read expected %0d got %0d", $time, idx, want, prdata);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_size(input logic [bb3_pkg::APB_DATA_W-1:0] w,
                          input logic [bb3_pkg::APB_DATA_W-1:0] h);
    write_reg(bb3_pkg::REG_WIDTH, w);
    write_reg(bb3_pkg::REG_HEIGHT, h);
    read_reg(bb3_pkg::REG_WIDTH);
    read_reg(bb3_pkg::REG_HEIGHT);
  endtask

  // Both registers come out of reset at the full frame size
  task automatic test_register_reset();
    read_reg(bb3_pkg::REG_WIDTH);
    read_reg(bb3_pkg::REG_HEIGHT);
  endtask

  // 4x3 frame of extremes; upper data bits beyond the register are dropped
  task automatic test_small_frame();
    bb3_pkg::pix_t pattern [12];
    pattern = '{8'd0, 8'd255, 8'd255, 8'd0,
                8'd255, 8'd255, 8'd255, 8'd255,
                8'd0, 8'd0, 8'd255, 8'd1};
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    set_size(32'hFFFF_F804, 32'd3);
    foreach (pattern[i]) send_pixel(pattern[i]);
  endtask

  // Zero sizes act as 1; single column and single row frames
  task automatic test_degenerate_sizes();
    set_size(32'd0, 32'd0);
    send_pixel(8'd255);
    send_pixel(8'd0);  // next frame follows without a write
    set_size(32'd1, 32'd3);
    send_pixel(8'd255);
    send_pixel(8'd7);
    send_pixel(8'd200);
    set_size(32'd3, 32'd1);
    send_pixel(8'd128);
    send_pixel(8'd255);
    send_pixel(8'd0);
  endtask

  // Width just past the maximum saturates instead of wrapping to its low bits;
  // pixels go back to back into the start of one row
  task automatic test_widest_row();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    set_size(32'd1025, 32'd1);
    repeat (SPAN_ITEMS) send_pixel(rand_pixel());
  endtask

  // Height just past the maximum saturates; one column runs down the rows
  task automatic test_tallest_column();
    set_size(32'd1, 32'd1025);
    repeat (SPAN_ITEMS) send_pixel(rand_pixel());
  endtask

  // Small random frames, mostly whole ones, some back to back, some cut short
  task automatic test_random_frames();
    int sent, w, h, frame_px, total;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = (w > 8) ? $urandom_range(1, 3) : $urandom_range(1, 8);
      case ($urandom_range(0, 5))
        0: write_reg(bb3_pkg::REG_WIDTH, w);
        1: write_reg(bb3_pkg::REG_HEIGHT, h);
        2: ;  // keep the current size and position
        default: begin
          write_reg(bb3_pkg::REG_WIDTH, w);
          write_reg(bb3_pkg::REG_HEIGHT, h);
        end
      endcase
      frame_px = eff_dim(width_reg, bb3_pkg::MAX_WIDTH) *
                 eff_dim(height_reg, bb3_pkg::MAX_HEIGHT);
      if (frame_px > 400) frame_px = 400;
      total = frame_px * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) total += $urandom_range(1, frame_px);
      for (int i = 0; i < total && sent < RANDOM_ITEMS; i++) begin
        send_pixel(rand_pixel());
        sent++;
        // hold the stream at a frame boundary until all results are out
        if (i == frame_px - 1 && $urandom_range(0, 3) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    pix_ch.valid    = 1'b0;
    pix_ch.pixel_in = '0;
    width_reg       = bb3_pkg::DIM_W'(bb3_pkg::MAX_WIDTH);
    height_reg      = bb3_pkg::DIM_W'(bb3_pkg::MAX_HEIGHT);
    col_pos         = 0;
    row_pos         = 0;
    errors          = 0;
    gaps_on         = 1'b1;
    stall_on        = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_register_reset();
    test_small_frame();
    test_degenerate_sizes();
    test_widest_row();
    test_tallest_column();
    test_random_frames();

    // drain: all results in, then let the pipeline settle to catch strays
    pix_ch.valid = 1'b0;
    while (expected_blur.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
